FILE: rtl/amld_pkg.sv
// Shared types and constants for the alpha map layer decoder.
package amld_pkg;

    localparam int TEXEL_COUNT = 4096;
    localparam int POS_W       = $clog2(TEXEL_COUNT) + 1;
    localparam int IDX_W       = $clog2(TEXEL_COUNT);
    localparam int ROW_STRIDE  = 64;
    localparam int LAST_COL    = ROW_STRIDE - 1;
    localparam int EDGE_COL    = ROW_STRIDE - 2;
    localparam int EDGE_ROW    = 62;
    localparam int FIX_LIMIT   = 63 * ROW_STRIDE;
    localparam int MAX_RESULTS = 4;
    localparam int SLOT_W      = $clog2(MAX_RESULTS);
    localparam int CNT_W       = SLOT_W + 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam logic [1:0] CFG_RLE_COMPRESSED  = 2'd0;
    localparam logic [1:0] CFG_EIGHT_BIT_ALPHA = 2'd1;
    localparam logic [1:0] CFG_SKIP_EDGE_FIX   = 2'd2;

    typedef enum logic [2:0] {
        PH_CODE = 3'b001,
        PH_FILL = 3'b010,
        PH_LIT  = 3'b100
    } phase_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [7:0]       val;
        logic [6:0]       len;
    } result_t;

    typedef struct packed {
        logic [CNT_W-1:0]                count;
        result_t [MAX_RESULTS-1:0]       res;
    } bundle_t;

    typedef struct packed {
        logic [POS_W-1:0] position;
        phase_t           phase;
    } front_status_t;

endpackage

FILE: rtl/amld_front.sv
// Front end: holds configuration and parse state, turns each source byte into a result bundle.
module amld_front
    import amld_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_wr_en,
    input  logic [1:0]    cfg_index,
    input  logic          cfg_wdata,
    input  logic          in_valid,
    input  logic [7:0]    src_byte,
    input  logic          last_byte,
    input  logic          q_full,
    output logic          in_stall,
    output logic          push,
    output bundle_t       push_data,
    output front_status_t status
);

    logic             rle_reg;
    logic             eight_reg;
    logic             skip_reg;
    phase_t           phase_reg;
    phase_t           phase_next;
    logic [6:0]       rr_reg;
    logic [6:0]       rr_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;

    logic             accept;
    logic [POS_W-1:0] pos_p1;
    logic [POS_W-1:0] room;
    logic [6:0]       fill_len;
    result_t [MAX_RESULTS-1:0] cand;
    logic [MAX_RESULTS-1:0]    cand_v;
    logic [CNT_W-1:0]          cnt;

    function automatic logic fix_ok(input logic [POS_W-1:0] p);
        fix_ok = (p < POS_W'(FIX_LIMIT)) && (p[5:0] != 6'(LAST_COL));
    endfunction

    function automatic logic [6:0] fix_len(input logic [POS_W-1:0] p);
        fix_len = (p[5:0] == 6'(EDGE_COL)) ? 7'd2 : 7'd1;
    endfunction

    function automatic logic fix_row(input logic [POS_W-1:0] p);
        fix_row = (p[IDX_W-1:6] == 6'(EDGE_ROW));
    endfunction

    assign accept   = in_valid && !q_full;
    assign in_stall = q_full;
    assign pos_p1   = pos_reg + POS_W'(1);
    assign room     = POS_W'(TEXEL_COUNT) - pos_reg;
    assign fill_len = ({{(POS_W-7){1'b0}}, rr_reg} > room) ? room[6:0] : rr_reg;

    always_comb
    begin
        phase_next = phase_reg;
        rr_next    = rr_reg;
        pos_next   = pos_reg;
        cand       = '0;
        cand_v     = '0;
        if (pos_reg < POS_W'(TEXEL_COUNT))
        begin
            if (rle_reg)
            begin
                unique case (phase_reg)
                    PH_FILL:
                    begin
                        cand[0] = '{idx: pos_reg[IDX_W-1:0], val: src_byte, len: fill_len};
                        cand_v[0] = (fill_len != 7'd0);
                        pos_next = pos_reg + {{(POS_W-7){1'b0}}, fill_len};
                        rr_next = 7'd0;
                        phase_next = PH_CODE;
                    end
                    PH_LIT:
                    begin
                        cand[0] = '{idx: pos_reg[IDX_W-1:0], val: src_byte, len: 7'd1};
                        cand_v[0] = 1'b1;
                        pos_next = pos_p1;
                        rr_next = rr_reg - 7'd1;
                        if (rr_reg == 7'd1)
                        begin
                            phase_next = PH_CODE;
                        end
                    end
                    PH_CODE:
                    begin
                        rr_next = src_byte[6:0];
                        if (src_byte[7])
                        begin
                            phase_next = PH_FILL;
                        end
                        else if (src_byte[6:0] != 7'd0)
                        begin
                            phase_next = PH_LIT;
                        end
                        else
                        begin
                            phase_next = PH_CODE;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_CODE;
                    end
                endcase
            end
            else if (eight_reg)
            begin
                cand[0] = '{idx: pos_reg[IDX_W-1:0], val: src_byte, len: 7'd1};
                cand_v[0] = 1'b1;
                pos_next = pos_p1;
            end
            else if (skip_reg)
            begin
                cand[0] = '{idx: pos_reg[IDX_W-1:0], val: {2{src_byte[3:0]}}, len: 7'd1};
                cand_v[0] = 1'b1;
                cand[2] = '{idx: pos_p1[IDX_W-1:0], val: {2{src_byte[7:4]}}, len: 7'd1};
                cand_v[2] = !pos_p1[POS_W-1];
                pos_next = pos_p1 + {{(POS_W-1){1'b0}}, !pos_p1[POS_W-1]};
            end
            else
            begin
                cand[0] = '{idx: pos_reg[IDX_W-1:0], val: {2{src_byte[3:0]}},
                            len: fix_len(pos_reg)};
                cand_v[0] = fix_ok(pos_reg);
                cand[1] = '{idx: pos_reg[IDX_W-1:0] + IDX_W'(ROW_STRIDE),
                            val: {2{src_byte[3:0]}}, len: fix_len(pos_reg)};
                cand_v[1] = fix_ok(pos_reg) && fix_row(pos_reg);
                cand[2] = '{idx: pos_p1[IDX_W-1:0], val: {2{src_byte[7:4]}},
                            len: fix_len(pos_p1)};
                cand_v[2] = fix_ok(pos_p1);
                cand[3] = '{idx: pos_p1[IDX_W-1:0] + IDX_W'(ROW_STRIDE),
                            val: {2{src_byte[7:4]}}, len: fix_len(pos_p1)};
                cand_v[3] = fix_ok(pos_p1) && fix_row(pos_p1);
                pos_next = pos_p1 + {{(POS_W-1){1'b0}}, !pos_p1[POS_W-1]};
            end
        end
        if (last_byte)
        begin
            phase_next = PH_CODE;
            rr_next    = 7'd0;
            pos_next   = '0;
        end
    end

    // Pack the valid candidates to the low slots, keeping their order.
    always_comb
    begin
        push_data = '0;
        cnt       = '0;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            if (cand_v[i])
            begin
                push_data.res[cnt[SLOT_W-1:0]] = cand[i];
                cnt = cnt + CNT_W'(1);
            end
        end
        push_data.count = cnt;
    end

    assign push   = accept && (cnt != '0);
    assign status = '{position: pos_reg, phase: phase_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rle_reg   <= 1'b0;
            eight_reg <= 1'b0;
            skip_reg  <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_RLE_COMPRESSED:  rle_reg   <= cfg_wdata;
                CFG_EIGHT_BIT_ALPHA: eight_reg <= cfg_wdata;
                CFG_SKIP_EDGE_FIX:   skip_reg  <= cfg_wdata;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_CODE;
            rr_reg    <= 7'd0;
            pos_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            rr_reg    <= rr_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

FILE: rtl/amld_queue.sv
// Short bundle queue between the front end and the back end.
module amld_queue
    import amld_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  bundle_t push_data,
    input  logic    pop,
    output bundle_t head,
    output logic    full,
    output logic    empty
);

    bundle_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

FILE: rtl/amld_back.sv
// Back end: walks each queued bundle and presents one texel write per cycle while out_stall is low.
module amld_back
    import amld_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  bundle_t          head,
    input  logic             q_empty,
    input  logic             out_stall,
    output logic             pop,
    output logic             out_valid,
    output logic [IDX_W-1:0] texel_index,
    output logic [7:0]       texel_value,
    output logic [6:0]       run_length,
    output logic             last_result
);

    logic [SLOT_W-1:0] sub_reg;
    logic              valid_reg;
    result_t           res_reg;
    logic              last_reg;
    logic              load;
    logic              is_last;
    result_t           cur;

    assign load    = !q_empty && (!valid_reg || !out_stall);
    assign cur     = head.res[sub_reg];
    assign is_last = ({1'b0, sub_reg} + CNT_W'(1)) == head.count;
    assign pop     = load && is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sub_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            sub_reg   <= is_last ? '0 : sub_reg + SLOT_W'(1);
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg  <= cur;
            last_reg <= is_last;
        end
    end

    assign out_valid   = valid_reg;
    assign texel_index = res_reg.idx;
    assign texel_value = res_reg.val;
    assign run_length  = res_reg.len;
    assign last_result = last_reg;

endmodule

FILE: rtl/alpha_map_layer_decoder.sv
// Top level of the alpha map layer decoder: front end, bundle queue and back end.
//
//  Channel | Direction | Handshake             | Payload
//  --------+-----------+-----------------------+-----------------------------------------------
//  input   | in        | in_valid / in_stall   | src_byte, last_byte
//  output  | out       | out_valid / out_stall | texel_index, texel_value, run_length, last_result
//  config  | in        | cfg_wr_en             | cfg_index, cfg_wdata
//
// While the queue is not full, the front end decodes one source byte per cycle into a
// bundle of up to four texel writes and pushes it into a two-entry queue; bytes with no
// write are not queued. The back end presents one write per cycle while out_stall is low.
// The queue lets the front end take new bytes while earlier bundles are still being written.
// Reset clears configuration, parse state, queue pointers and the output valid flag at once.
// in_stall is high only while the queue is full; a stalled output holds its register.
module alpha_map_layer_decoder
    import amld_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic             cfg_wdata,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       src_byte,
    input  logic             last_byte,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [IDX_W-1:0] texel_index,
    output logic [7:0]       texel_value,
    output logic [6:0]       run_length,
    output logic             last_result
);

    logic          q_push;
    logic          q_pop;
    logic          q_full;
    logic          q_empty;
    bundle_t       push_data;
    bundle_t       head;
    front_status_t front_status;

    // The front end owns configuration and all per-layer parse state.
    amld_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .src_byte  (src_byte),
        .last_byte (last_byte),
        .q_full    (q_full),
        .in_stall  (in_stall),
        .push      (q_push),
        .push_data (push_data),
        .status    (front_status)
    );

    // Bytes that produce no texel write never enter the queue.
    amld_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    // The back end pops a bundle once its final write has been loaded into the output register.
    amld_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_empty     (q_empty),
        .out_stall   (out_stall),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .texel_index (texel_index),
        .texel_value (texel_value),
        .run_length  (run_length),
        .last_result (last_result)
    );

`ifndef NO_ASSERTIONS
    // A push must never land on a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("bundle pushed into a full queue");

    // A pop needs a bundle at the head.
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
        else $error("bundle popped from an empty queue");

    // Every write presented covers at least one texel.
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> run_length != 7'd0)
        else $error("texel write with zero run length");

    // The final byte of a layer leaves the parser at the start of a fresh layer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && last_byte) |=>
            (front_status.position == '0) && (front_status.phase == PH_CODE))
        else $error("parse state not cleared after the final byte");
`endif

endmodule
